// File: design/quick_advection_explicit_step_1d_defines.svh
// Assertion macros shared by the QUICK advection step block.
// No dependencies; included by the top level, which holds the assertions.
`ifndef QUICK_ADVECTION_EXPLICIT_STEP_1D_DEFINES_SVH
`define QUICK_ADVECTION_EXPLICIT_STEP_1D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QAE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qae: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QAE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qae: next-cycle check failed");

`endif

// File: design/qae_pkg.sv
// Shared types and constants of the QUICK advection step block.
// No dependencies; the front, queue, back and top level import it.
package qae_pkg;

    // Fixed-point format of the Courant factor and of the products.
    localparam int FRAC_BITS     = 16;
    localparam int COURANT_WIDTH = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COURANT = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INLET   = 1'd1;

    // Position of a cell within its row, saturating at the interior code.
    typedef logic [1:0] cell_pos_t;
    localparam cell_pos_t POS_FIRST  = 2'd0;
    localparam cell_pos_t POS_SECOND = 2'd1;
    localparam cell_pos_t POS_THIRD  = 2'd2;
    localparam cell_pos_t POS_INNER  = 2'd3;

    // Classification that the front attaches to every accepted cell.
    typedef struct packed {
        cell_pos_t position;
        logic      last;
    } cell_tag_t;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: design/qae_if.sv
// Stream channels of the QUICK advection step block: cells in, updates out.
// Valid/ready handshake; no package dependency.
interface qae_sample_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           row_end;

    modport source (output valid, output sample_value, output row_end, input ready);
    modport sink   (input valid, input sample_value, input row_end, output ready);
endinterface

interface qae_result_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] new_value;
    logic                           final_result;

    modport source (output valid, output new_value, output final_result, input ready);
    modport sink   (input valid, input new_value, input final_result, output ready);
endinterface

// File: design/qae_front.sv
// Front of the QUICK advection step: accepts cells and tags each with its row position.
// Depends on qae_pkg and qae_sample_if.
module qae_front import qae_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    qae_sample_if.sink              cells,
    input  logic                    q_full,
    output logic                    push,
    output logic [SAMPLE_WIDTH-1:0] push_sample,
    output cell_tag_t               push_tag
);

    cell_pos_t pos_reg;
    cell_pos_t pos_next;

    assign cells.ready = !q_full;
    assign push        = cells.valid && !q_full;
    assign push_sample = cells.sample_value;

    always_comb
    begin
        push_tag.position = pos_reg;
        push_tag.last     = cells.row_end;
    end

    // The position restarts after the last cell of a row and otherwise
    // counts up until it reaches the interior code.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (cells.row_end)
            begin
                pos_next = POS_FIRST;
            end
            else if (pos_reg != POS_INNER)
            begin
                pos_next = pos_reg + cell_pos_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: design/qae_queue.sv
// Short queue that decouples the front from the back of the advection step.
// Depends on qae_pkg.
module qae_queue import qae_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [SAMPLE_WIDTH-1:0] push_sample,
    input  cell_tag_t               push_tag,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output logic [SAMPLE_WIDTH-1:0] head_sample,
    output cell_tag_t               head_tag
);

    logic [SAMPLE_WIDTH-1:0] sample_mem [QUEUE_DEPTH];
    cell_tag_t               tag_mem    [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]   wr_ptr_reg;
    logic [QPTR_WIDTH-1:0]   rd_ptr_reg;
    logic [QCNT_WIDTH-1:0]   count_reg;
    logic [QCNT_WIDTH-1:0]   count_next;

    assign full        = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign head_valid  = (count_reg != '0);
    assign head_sample = sample_mem[rd_ptr_reg];
    assign head_tag    = tag_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sample_mem[wr_ptr_reg] <= push_sample;
            tag_mem[wr_ptr_reg]    <= push_tag;
        end
    end

endmodule

// File: design/qae_back.sv
// Back of the QUICK advection step: inlet adjust, stencil sums, Courant scaling,
// saturation and the two-slot result register. Depends on qae_pkg and qae_result_if.
module qae_back import qae_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [COURANT_WIDTH-1:0]       courant,
    input  logic signed [SAMPLE_WIDTH-1:0] inlet,
    input  logic                           head_valid,
    input  logic [SAMPLE_WIDTH-1:0]        head_sample,
    input  cell_tag_t                      head_tag,
    output logic                           pop,
    qae_result_if.source                   updates
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int XW = SW + 4;              // stencil sums, up to 14 times a sample
    localparam int DW = XW + 1;              // center minus scaled sum
    localparam int PW = SW + COURANT_WIDTH;  // Courant factor times inlet

    // Saturate a difference to the sample range.
    function automatic logic [SW-1:0] clamp_w(input logic [DW-1:0] v);
        priority if (v[DW-1:SW-1] == {(DW-SW+1){v[DW-1]}})
            return v[SW-1:0];
        else if (v[DW-1])
            return {1'b1, {(SW-1){1'b0}}};
        else
            return {1'b0, {(SW-1){1'b1}}};
    endfunction

    function automatic logic signed [XW-1:0] ext_x(input logic [SW-1:0] v);
        return {{(XW-SW){v[SW-1]}}, v};
    endfunction

    function automatic logic signed [DW-1:0] ext_d(input logic [SW-1:0] v);
        return {{(DW-SW){v[SW-1]}}, v};
    endfunction

    // Inlet terms, derived from the configuration.
    logic signed [PW:0]      inlet_prod;
    logic signed [PW-1:0]    p_reg;
    logic signed [PW+2:0]    p_ext;
    logic signed [PW+2:0]    p5;
    logic [SW-1:0]           inl1;
    logic [SW+2:0]           inl5;

    // Stage A: adjusted cell value.
    logic                    adv;
    logic signed [DW-1:0]    adj_sum;
    logic                    a_valid_reg;
    logic [SW-1:0]           a_x_reg;
    cell_tag_t               a_tag_reg;

    // Window of the three previous adjusted cells, oldest first.
    logic [SW-1:0]           win0_reg;
    logic [SW-1:0]           win1_reg;
    logic [SW-1:0]           win2_reg;

    // Stage B: stencil sums.
    logic signed [XW-1:0]    xe;
    logic signed [XW-1:0]    w0e;
    logic signed [XW-1:0]    w1e;
    logic signed [XW-1:0]    w2e;
    logic signed [XW-1:0]    x3;
    logic signed [XW-1:0]    w2x3;
    logic signed [XW-1:0]    w1x7;
    logic signed [XW-1:0]    main_sum;
    logic signed [XW-1:0]    last_sum;
    logic                    b_valid_reg;
    logic signed [XW-1:0]    b_main_sum_reg;
    logic signed [XW-1:0]    b_last_sum_reg;
    logic [SW-1:0]           b_main_ctr_reg;
    logic [SW-1:0]           b_last_ctr_reg;
    logic                    b_has_main_reg;
    logic                    b_has_last_reg;

    // Stage C: sums scaled by the Courant factor.
    logic signed [XW+16:0]   main_prod;
    logic signed [XW+16:0]   last_prod;
    logic                    c_valid_reg;
    logic signed [XW-1:0]    c_main_scaled_reg;
    logic signed [XW-1:0]    c_last_scaled_reg;
    logic [SW-1:0]           c_main_ctr_reg;
    logic [SW-1:0]           c_last_ctr_reg;
    logic                    c_has_main_reg;
    logic                    c_has_last_reg;

    // Result slots: the ordinary result goes out before the last-cell result.
    logic signed [DW-1:0]    main_diff;
    logic signed [DW-1:0]    last_diff;
    logic [SW-1:0]           out_main_reg;
    logic [SW-1:0]           out_last_reg;
    logic                    out_main_vld_reg;
    logic                    out_last_vld_reg;

    assign inlet_prod = inlet * $signed({1'b0, courant});
    assign p_ext      = {{3{p_reg[PW-1]}}, p_reg};
    assign p5         = (p_ext <<< 2) + p_ext;
    assign inl1       = p_reg[PW-1:FRAC_BITS];
    assign inl5       = p5[PW+2:FRAC_BITS];

    // The whole back advances together unless the result slots cannot drain.
    assign adv = !(out_main_vld_reg || out_last_vld_reg) ||
                 (updates.ready && !(out_main_vld_reg && out_last_vld_reg));
    assign pop = adv && head_valid;

    always_comb
    begin
        unique case (head_tag.position)
            POS_FIRST:
            begin
                adj_sum = ext_d(head_sample) + {{(DW-SW-3){inl5[SW+2]}}, inl5};
            end
            POS_SECOND:
            begin
                adj_sum = ext_d(head_sample) - ext_d(inl1);
            end
            POS_THIRD, POS_INNER:
            begin
                adj_sum = ext_d(head_sample);
            end
        endcase
    end

    assign xe   = ext_x(a_x_reg);
    assign w0e  = ext_x(win0_reg);
    assign w1e  = ext_x(win1_reg);
    assign w2e  = ext_x(win2_reg);
    assign x3   = (xe <<< 1) + xe;
    assign w2x3 = (w2e <<< 1) + w2e;
    assign w1x7 = (w1e <<< 3) - w1e;

    always_comb
    begin
        unique case (a_tag_reg.position)
            POS_FIRST:  main_sum = '0;
            POS_SECOND: main_sum = (w2e <<< 1) + x3;
            POS_THIRD:  main_sum = (w2x3 + x3) - w1x7;
            POS_INNER:  main_sum = (w0e + w2x3) + (x3 - w1x7);
        endcase
    end

    assign last_sum = w1e - (xe <<< 1) - (w2x3 <<< 1);

    assign main_prod = b_main_sum_reg * $signed({1'b0, courant});
    assign last_prod = b_last_sum_reg * $signed({1'b0, courant});

    assign main_diff = ext_d(c_main_ctr_reg) - {c_main_scaled_reg[XW-1], c_main_scaled_reg};
    assign last_diff = ext_d(c_last_ctr_reg) - {c_last_scaled_reg[XW-1], c_last_scaled_reg};

    assign updates.valid        = out_main_vld_reg || out_last_vld_reg;
    assign updates.new_value    = out_main_vld_reg ? out_main_reg : out_last_reg;
    assign updates.final_result = !out_main_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            out_main_vld_reg <= 1'b0;
            out_last_vld_reg <= 1'b0;
            win0_reg         <= '0;
            win1_reg         <= '0;
            win2_reg         <= '0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg      <= head_valid;
                b_valid_reg      <= a_valid_reg;
                c_valid_reg      <= b_valid_reg;
                out_main_vld_reg <= c_valid_reg && c_has_main_reg;
                out_last_vld_reg <= c_valid_reg && c_has_last_reg;
                if (a_valid_reg)
                begin
                    if (a_tag_reg.last)
                    begin
                        win0_reg <= '0;
                        win1_reg <= '0;
                        win2_reg <= '0;
                    end
                    else
                    begin
                        win0_reg <= win1_reg;
                        win1_reg <= win2_reg;
                        win2_reg <= a_x_reg;
                    end
                end
            end
            else if (updates.ready)
            begin
                // Both slots are full here: the ordinary result leaves first.
                out_main_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= inlet_prod[PW-1:0];
        if (adv)
        begin
            a_x_reg           <= clamp_w(adj_sum);
            a_tag_reg         <= head_tag;
            b_main_sum_reg    <= main_sum;
            b_last_sum_reg    <= last_sum;
            b_main_ctr_reg    <= win2_reg;
            b_last_ctr_reg    <= a_x_reg;
            b_has_main_reg    <= (a_tag_reg.position != POS_FIRST);
            b_has_last_reg    <= a_tag_reg.last;
            c_main_scaled_reg <= main_prod[XW+FRAC_BITS-1:FRAC_BITS];
            c_last_scaled_reg <= last_prod[XW+FRAC_BITS-1:FRAC_BITS];
            c_main_ctr_reg    <= b_main_ctr_reg;
            c_last_ctr_reg    <= b_last_ctr_reg;
            c_has_main_reg    <= b_has_main_reg;
            c_has_last_reg    <= b_has_last_reg;
            out_main_reg      <= clamp_w(main_diff);
            out_last_reg      <= clamp_w(last_diff);
        end
    end

endmodule

// File: design/quick_advection_explicit_step_1d.sv
// Top level of the QUICK upwind advection step: configuration registers,
// front, queue and back. Depends on qae_pkg, qae_if and the defines header.
`include "quick_advection_explicit_step_1d_defines.svh"

// This block computes one explicit time step of 1D QUICK upwind advection
// over a row of signed Q16.16 cells streamed in cell order, one cell per
// transfer on the cells channel, with row_end set on the last cell of a row.
// Each update is new[i] = u[i] - c*stencil, saturated to the sample range,
// where c is the unsigned Q0.16 Courant factor and products are truncated
// toward minus infinity. The first two cells of a row first take the inlet
// term (plus five times c*inlet, then minus c*inlet). Updates lag the cells
// by one: the first cell of a row gives no update, and the last cell gives
// two, the second of them marked with final_result. A row must hold at
// least four cells. The block takes one cell per clock cycle, sustained;
// the only stall it makes on its own is for the extra update of a row's last
// cell, which the two-slot result register sends out separately.
// A cell passes through the two-entry queue, then inlet adjust, stencil
// sums, Courant multiply and the saturating subtract into the result
// register. While updates are stalled the queue keeps accepting until it is
// full. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while no row is in flight, and the block itself does not
// enforce this. The inlet terms also wait for the registered c*inlet.
module quick_advection_explicit_step_1d import qae_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    qae_sample_if.sink                 cells,
    qae_result_if.source               updates,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]    cfg_data
);

    logic [COURANT_WIDTH-1:0]       courant_reg;
    logic signed [SAMPLE_WIDTH-1:0] inlet_reg;

    logic                    q_push;
    logic [SAMPLE_WIDTH-1:0] q_push_sample;
    cell_tag_t               q_push_tag;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_head_valid;
    logic [SAMPLE_WIDTH-1:0] q_head_sample;
    cell_tag_t               q_head_tag;

    // Configuration writes land directly in the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            courant_reg <= '0;
            inlet_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COURANT: courant_reg <= cfg_data[COURANT_WIDTH-1:0];
                REG_INLET:   inlet_reg   <= cfg_data;
            endcase
        end
    end

    // The front tags each cell with its position in the row.
    qae_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cells       (cells),
        .q_full      (q_full),
        .push        (q_push),
        .push_sample (q_push_sample),
        .push_tag    (q_push_tag)
    );

    // The queue lets the front keep taking cells while the back is stalled.
    qae_queue #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_sample (q_push_sample),
        .push_tag    (q_push_tag),
        .full        (q_full),
        .pop         (q_pop),
        .head_valid  (q_head_valid),
        .head_sample (q_head_sample),
        .head_tag    (q_head_tag)
    );

    // The back does the arithmetic and holds the pending updates.
    qae_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .courant     (courant_reg),
        .inlet       (inlet_reg),
        .head_valid  (q_head_valid),
        .head_sample (q_head_sample),
        .head_tag    (q_head_tag),
        .pop         (q_pop),
        .updates     (updates)
    );

    // A stalled update must freeze the back, so nothing leaves the queue.
    `QAE_ASSERT_IMP(a_stall_holds_queue, clk, rst_n, updates.valid && !updates.ready, !q_pop)
    // The back only takes a cell that the queue holds.
    `QAE_ASSERT_IMP(a_pop_needs_entry, clk, rst_n, q_pop, q_head_valid)
    // A Courant write is in the register on the next cycle.
    `QAE_ASSERT_NXT(a_courant_write, clk, rst_n, cfg_we && cfg_index == REG_COURANT, courant_reg == $past(cfg_data[COURANT_WIDTH-1:0]))

endmodule

// File: test/qae_step_checker.sv
// Checker for the QUICK advection step block: watches cells, updates and config writes.
// Predicts every update and compares it with what the block sends.
// Depends on qae_pkg and the channel interfaces in qae_if.sv.
module qae_step_checker import qae_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    qae_sample_if                      cells,
    qae_result_if                      updates,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]    cfg_data,
    output int unsigned                fail_count,
    output int unsigned                pending_updates
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    last;
    } cell_update_t;

    logic [COURANT_WIDTH-1:0] courant;
    longint                   inlet;
    longint                   cell_hist [3];
    cell_pos_t                row_pos;
    cell_update_t             expected_updates [$];
    int unsigned              mismatches;

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (v < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return v;
    endfunction

    // c*v in Q0.16, rounded toward minus infinity.
    function automatic longint times_courant(input longint v);
        return (v * longint'({48'd0, courant})) >>> FRAC_BITS;
    endfunction

    function automatic void expect_update(input longint center, input longint stencil,
                                          input logic last);
        cell_update_t u;
        u.value = SAMPLE_WIDTH'(clamp_sample(center - times_courant(stencil)));
        u.last  = last;
        expected_updates.push_back(u);
    endfunction

    // Advances the row state by one cell and queues the updates it releases.
    function automatic void take_cell(input longint raw, input logic last);
        longint x;
        longint w0;
        longint w1;
        longint w2;
        x  = raw;
        w0 = cell_hist[0];
        w1 = cell_hist[1];
        w2 = cell_hist[2];
        if (row_pos == POS_FIRST)
        begin
            x = clamp_sample(x + times_courant(inlet * 5));
        end
        else if (row_pos == POS_SECOND)
        begin
            x = clamp_sample(x - times_courant(inlet));
        end

        case (row_pos)
            POS_SECOND: expect_update(w2, 2 * w2 + 3 * x, 1'b0);
            POS_THIRD:  expect_update(w2, -7 * w1 + 3 * w2 + 3 * x, 1'b0);
            POS_INNER:  expect_update(w2, w0 - 7 * w1 + 3 * w2 + 3 * x, 1'b0);
            default:    ;
        endcase

        if (last)
        begin
            expect_update(x, -2 * x - 6 * w2 + w1, 1'b1);
            cell_hist = '{0, 0, 0};
            row_pos   = POS_FIRST;
        end
        else
        begin
            cell_hist = '{w1, w2, x};
            if (row_pos != POS_INNER)
            begin
                row_pos = row_pos + 2'd1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_update_t want;
        if (!rst_n)
        begin
            courant    = '0;
            inlet      = 0;
            cell_hist  = '{0, 0, 0};
            row_pos    = POS_FIRST;
            mismatches = 0;
            expected_updates.delete();
            fail_count      <= 0;
            pending_updates <= 0;
        end
        else
        begin
            // Results never leave in the same cycle as their cell, so check first.
            if (updates.valid && updates.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $display("%0t: update with nothing expected: new_value %0d final_result %0b",
                             $time, $signed(updates.new_value), updates.final_result);
                    mismatches++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (updates.new_value !== want.value)
                    begin
                        $display("%0t: new_value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(updates.new_value));
                        mismatches++;
                    end
                    if (updates.final_result !== want.last)
                    begin
                        $display("%0t: final_result expected %0b actual %0b", $time,
                                 want.last, updates.final_result);
                        mismatches++;
                    end
                end
            end
            if (cells.valid && cells.ready)
            begin
                take_cell(longint'($signed(cells.sample_value)), cells.row_end);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_COURANT)
                begin
                    courant = cfg_data[COURANT_WIDTH-1:0];
                end
                else if (cfg_index == REG_INLET)
                begin
                    inlet = longint'($signed(cfg_data));
                end
            end
            fail_count      <= mismatches;
            pending_updates <= expected_updates.size();
        end
    end

endmodule

// File: test/quick_advection_explicit_step_1d_tb.sv
// Top of the QUICK advection step testbench: clock, reset, stimulus and verdict.
// Depends on qae_pkg, qae_if.sv, the block itself and qae_step_checker.
module quick_advection_explicit_step_1d_tb;
    import qae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_WIDTH = 32;
    // Random cells to send, and how many of the last ones go without idling.
    localparam int ITEM_TARGET  = 1950;
    localparam int STEADY_ITEMS = 200;
    // A cell passes the queue and the back's registers before its update leaves;
    // a row's first cell makes no update, so after the queue drains we still give the
    // pipeline this many cycles before touching the registers.
    localparam int SETTLE_CYCLES = 12;
    // Cycles without any transfer or register write before the run is abandoned.
    localparam int QUIET_LIMIT = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [SAMPLE_WIDTH-1:0]    cfg_data;
    int unsigned                fail_count;
    int unsigned                pending_updates;
    int unsigned                quiet_cycles = 0;
    int                         cells_sent;
    int                         gap_pct;
    int                         stall_pct;
    bit                         steady;

    qae_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) cells_ch ();
    qae_result_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) upd_ch ();

    quick_advection_explicit_step_1d #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cells_ch),
        .updates   (upd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qae_step_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cells           (cells_ch),
        .updates         (upd_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_updates (pending_updates)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The update side stalls in bursts of random length. A burst starts
    // with a chance of stall_pct percent on each cycle; with stall_pct at zero
    // the sink simply takes every update it is offered.
    initial
    begin
        int burst;
        upd_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!steady && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 8);
                upd_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            upd_ch.ready <= 1'b1;
        end
    end

    // Watchdog: any transfer on either channel, or a register write, counts as
    // progress. A long stretch with none of them means the block is stuck or
    // is holding back updates that the checker is still waiting for.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cells_ch.valid && cells_ch.ready) || (upd_ch.valid && upd_ch.ready) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one cell and returns at the edge where its transfer happens.
    // Before the cell the source may go quiet for a burst of random length,
    // which lands the gap on whatever stage the row has reached.
    task automatic send_cell(input logic [SAMPLE_WIDTH-1:0] value, input logic last);
        int gap;
        if (!steady && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 8);
            cells_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cells_ch.valid        <= 1'b1;
        cells_ch.sample_value <= value;
        cells_ch.row_end      <= last;
        do @(posedge clk); while (!cells_ch.ready);
        cells_sent++;
    endtask

    task automatic send_row(input logic [SAMPLE_WIDTH-1:0] row [$]);
        for (int k = 0; k < row.size(); k++)
        begin
            send_cell(row[k], k == row.size() - 1);
        end
    endtask

    // Stops sending and waits for every predicted update to come out. The
    // pending count is registered in the checker, which only makes the wait
    // longer, never shorter.
    task automatic wait_drained();
        cells_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_updates != 0);
    endtask

    // Register writes only happen with the block idle, so the pipeline is
    // drained and allowed to settle first. The block registers c*inlet, so the
    // task waits for a new setting to pass that register before the next row.
    task automatic load_settings(input logic [COURANT_WIDTH-1:0] courant, input logic
                                 [SAMPLE_WIDTH-1:0] inlet, input bit set_courant,
                                 input bit set_inlet);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (set_courant)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_COURANT;
            cfg_data  <= SAMPLE_WIDTH'(courant);
            @(posedge clk);
        end
        if (set_inlet)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_INLET;
            cfg_data  <= inlet;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Cell values: mostly full-range random or moderate physical values, and
    // now and then one of the range ends or zero to hit the saturation paths.
    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [SAMPLE_WIDTH-1:0]  row [$];
        logic [COURANT_WIDTH-1:0] courant;
        logic [SAMPLE_WIDTH-1:0]  inlet;
        int                       which;
        int                       rows;
        int                       len;

        cells_ch.valid        = 1'b0;
        cells_ch.sample_value = '0;
        cells_ch.row_end      = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_COURANT;
        cfg_data              = '0;
        cells_sent            = 0;
        gap_pct               = 0;
        stall_pct             = 0;
        steady                = 1'b0;
        rst_n                 = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows. With c at zero every update must equal its cell, the
        // range ends included.
        load_settings(16'd0, 32'h0, 1'b1, 1'b1);
        row = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        send_row(row);

        // Largest Courant factor and inlet: the inlet terms and the stencils
        // drive the adjusted cells and the updates into both saturation limits.
        load_settings(16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
        row = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        send_row(row);

        // Short rows of one, two and three cells, where missing neighbours
        // read as zero, under the most negative inlet and with the sink stalling.
        stall_pct = 25;
        load_settings(16'h8000, 32'h8000_0000, 1'b1, 1'b1);
        row = '{32'h0001_0000};
        send_row(row);
        row = '{32'hFFFF_0000, 32'h0002_0000};
        send_row(row);
        row = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000};
        send_row(row);

        // Smallest nonzero factor on a plain row with fractional parts, so the
        // truncation toward minus infinity shows on negative stencils.
        gap_pct = 25;
        load_settings(16'd1, 32'h0003_0000, 1'b1, 1'b1);
        row = '{32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_0001,
                32'hFFFF_FFFF, 32'h0005_0000};
        send_row(row);

        // Random phases: each one picks new settings, then streams a few rows
        // that always end with row_end so that no row is in flight at the next
        // register write. The last stretch runs with no idling at all.
        while (cells_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 4))
                0:       courant = 16'd0;
                1:       courant = 16'hFFFF;
                2:       courant = COURANT_WIDTH'($urandom_range(0, 2047));
                default: courant = COURANT_WIDTH'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       inlet = 32'h7FFF_FFFF;
                1:       inlet = 32'h8000_0000;
                2:       inlet = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                default: inlet = $urandom;
            endcase
            which = $urandom_range(0, 3);
            load_settings(courant, inlet, which != 1, which != 0);

            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 30;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                2:       stall_pct = 15;
                default: stall_pct = 40;
            endcase

            rows = $urandom_range(1, 6);
            for (int r = 0; r < rows && cells_sent < ITEM_TARGET; r++)
            begin
                steady = cells_sent >= ITEM_TARGET - STEADY_ITEMS;
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(1, 3);
                    1:       len = $urandom_range(40, 120);
                    default: len = $urandom_range(4, 24);
                endcase
                for (int k = 0; k < len; k++)
                begin
                    // Now and then hold the source back in mid-row until every
                    // update owed so far has come out.
                    if (!steady && $urandom_range(0, 299) == 0)
                    begin
                        wait_drained();
                    end
                    send_cell(pick_sample(), k == len - 1);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/qae_pkg.sv
design/qae_if.sv
design/qae_front.sv
design/qae_queue.sv
design/qae_back.sv
design/quick_advection_explicit_step_1d.sv
test/qae_step_checker.sv
test/quick_advection_explicit_step_1d_tb.sv
